@@ hw/rtl/smuxfd_pkg.sv @@
// ----------------------------------------------------------------------------
// smuxfd_pkg
// Shared codes, widths and word types of the multiplexed-stream deframer.
// ----------------------------------------------------------------------------
package smuxfd_pkg;

  localparam int HEADER_BYTES = 8;
  localparam int HDR_CNT_W    = $clog2(HEADER_BYTES);

  // Event codes
  localparam logic [2:0] EV_PUSH        = 3'd0;
  localparam logic [2:0] EV_DONE        = 3'd1;
  localparam logic [2:0] EV_UPDATE      = 3'd2;
  localparam logic [2:0] EV_BAD_VERSION = 3'd3;
  localparam logic [2:0] EV_TOO_LONG    = 3'd4;
  localparam logic [2:0] EV_BAD_UPDATE  = 3'd5;
  localparam logic [2:0] EV_BAD_COMMAND = 3'd6;

  // Command bytes
  localparam logic [7:0] CMD_SYN    = 8'd0;
  localparam logic [7:0] CMD_FIN    = 8'd1;
  localparam logic [7:0] CMD_PUSH   = 8'd2;
  localparam logic [7:0] CMD_NOP    = 8'd3;
  localparam logic [7:0] CMD_UPDATE = 8'd4;

  // Configuration register indexes
  localparam logic CFG_VERSION = 1'b0;
  localparam logic CFG_MAX_LEN = 1'b1;

  localparam logic [1:0]  VERSION_RESET = 2'd1;
  localparam logic [15:0] MAX_LEN_RESET = 16'd32768;
  localparam logic [1:0]  UPDATE_VERSION = 2'd2;
  localparam logic [15:0] UPDATE_LEN     = 16'd8;

  typedef struct packed {
    logic [1:0]  expected_version;
    logic [15:0] max_payload_len;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [7:0]  command;
    logic [31:0] strm_id;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [31:0] peer_consumed;
    logic [31:0] peer_window;
  } res_t;

endpackage

@@ hw/rtl/smuxfd_core.sv @@
// ----------------------------------------------------------------------------
// smuxfd_core
// Per-byte frame parser: header assembly, checks, payload count-out and the
// combinational result word for the byte being taken.
// ----------------------------------------------------------------------------
module smuxfd_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [7:0]          rx_byte,
  input  smuxfd_pkg::cfg_t    cfg,
  output logic                emit,
  output smuxfd_pkg::res_t    res
);
  import smuxfd_pkg::*;

  logic                 failed, failed_next;
  logic                 in_payload, in_payload_next;
  logic [HDR_CNT_W-1:0] header_count, header_count_next;
  logic [63:0]          header_bytes, header_bytes_next;
  logic [15:0]          payload_left, payload_left_next;
  logic [63:0]          update_bytes, update_bytes_next;
  logic [3:0]           pay_count, pay_count_next;

  logic [63:0] hdr;
  logic [7:0]  cmd;
  logic [15:0] hdr_len;
  logic        frame_end;
  logic        end_emit;
  logic        end_fail;
  logic [2:0]  end_ev;

  // Header view: the incoming byte completes it on the last header byte
  assign header_bytes_next = in_payload ? header_bytes : {rx_byte, header_bytes[63:8]};
  assign hdr     = header_bytes_next;
  assign cmd     = hdr[15:8];
  assign hdr_len = hdr[31:16];

  // Frame-end outcome by command
  always_comb begin
    end_emit = 1'b1;
    end_fail = 1'b0;
    end_ev   = EV_DONE;
    case (cmd) inside
      CMD_SYN, CMD_FIN, CMD_NOP: end_ev = EV_DONE;
      CMD_PUSH:                  end_emit = 1'b0;
      CMD_UPDATE: begin
        if (cfg.expected_version != UPDATE_VERSION || hdr_len != UPDATE_LEN) begin
          end_ev   = EV_BAD_UPDATE;
          end_fail = 1'b1;
        end else begin
          end_ev = EV_UPDATE;
        end
      end
      default: begin
        end_ev   = EV_BAD_COMMAND;
        end_fail = 1'b1;
      end
    endcase
  end

  // Next state and result word
  always_comb begin
    failed_next       = failed;
    in_payload_next   = in_payload;
    header_count_next = header_count;
    payload_left_next = payload_left;
    update_bytes_next = update_bytes;
    pay_count_next    = pay_count;
    frame_end         = 1'b0;
    emit              = 1'b0;
    res               = '0;
    res.command       = cmd;
    res.strm_id       = hdr[63:32];
    if (take && !failed) begin
      if (!in_payload) begin
        if (header_count != HDR_CNT_W'(HEADER_BYTES - 1)) begin
          header_count_next = header_count + 1'b1;
        end else begin
          header_count_next = '0;
          update_bytes_next = '0;
          pay_count_next    = '0;
          if (hdr[7:0] != {6'd0, cfg.expected_version}) begin
            failed_next   = 1'b1;
            emit          = 1'b1;
            res.event_res = EV_BAD_VERSION;
          end else if (hdr_len > cfg.max_payload_len) begin
            failed_next   = 1'b1;
            emit          = 1'b1;
            res.event_res = EV_TOO_LONG;
          end else if (hdr_len == 16'd0) begin
            frame_end = 1'b1;
          end else begin
            in_payload_next   = 1'b1;
            payload_left_next = hdr_len;
          end
        end
      end else begin
        // collect the first eight payload bytes for update frames
        if (!pay_count[3]) begin
          update_bytes_next = {rx_byte, update_bytes[63:8]};
          pay_count_next    = pay_count + 1'b1;
        end
        payload_left_next = payload_left - 1'b1;
        if (payload_left_next == 16'd0) begin
          in_payload_next = 1'b0;
        end
        if (cmd == CMD_PUSH) begin
          emit          = 1'b1;
          res.event_res = EV_PUSH;
          res.data_byte = rx_byte;
          res.last_byte = (payload_left_next == 16'd0);
        end else if (payload_left_next == 16'd0) begin
          frame_end = 1'b1;
        end
      end
      if (frame_end) begin
        emit          = end_emit;
        res.event_res = end_ev;
        failed_next   = end_fail;
        if (end_ev == EV_UPDATE) begin
          res.peer_consumed = update_bytes_next[31:0];
          res.peer_window   = update_bytes_next[63:32];
        end
      end
    end
  end

  // Hold state, advance on a taken byte
  always_ff @(posedge clk) begin
    if (rst) begin
      failed       <= 1'b0;
      in_payload   <= 1'b0;
      header_count <= '0;
      header_bytes <= '0;
      payload_left <= '0;
      update_bytes <= '0;
      pay_count    <= '0;
    end else if (take && !failed) begin
      failed       <= failed_next;
      in_payload   <= in_payload_next;
      header_count <= header_count_next;
      header_bytes <= header_bytes_next;
      payload_left <= payload_left_next;
      update_bytes <= update_bytes_next;
      pay_count    <= pay_count_next;
    end
  end

  // Sticky failure never clears outside reset
  a_failed_sticky: assert property (@(posedge clk) disable iff (rst)
    failed |=> failed)
    else $error("failed flag cleared without reset");

  // A failed parser produces nothing
  a_no_emit_failed: assert property (@(posedge clk) disable iff (rst)
    failed |-> !emit)
    else $error("result produced after failure");

  // Header counting only while outside a payload
  a_hdr_count_idle: assert property (@(posedge clk) disable iff (rst)
    in_payload |-> header_count == '0)
    else $error("header count moved during payload");

  // Payload phase always has bytes left
  a_left_nonzero: assert property (@(posedge clk) disable iff (rst)
    in_payload |-> payload_left != 16'd0)
    else $error("payload phase with zero bytes left");

endmodule

@@ hw/rtl/smux_frame_deframer_unit.sv @@
// Output: a result word appears on the output register in the cycle after
//   the byte that causes it is taken.
// Throughput: one byte per cycle; the input stalls only while a result word
//   waits in the output register and the output is stalled.
// Reset: synchronous, active high; clears parser state, the output register
//   valid and loads version 1 and maximum payload 32768.
// ----------------------------------------------------------------------------
// smux_frame_deframer_unit
// Receive deframer for a multiplexed-stream link with config registers and
// a registered result word.
// ----------------------------------------------------------------------------
module smux_frame_deframer_unit (
  input  logic        clk,
  input  logic        rst,
  // receive byte channel
  input  logic        rx_valid,
  output logic        rx_stall,
  input  logic [7:0]  rx_byte,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  // result channel
  output logic        res_valid,
  input  logic        res_stall,
  output logic [2:0]  event_res,
  output logic [7:0]  command,
  output logic [31:0] strm_id,
  output logic [7:0]  data_byte,
  output logic        last_byte,
  output logic [31:0] peer_consumed,
  output logic [31:0] peer_window
);
  import smuxfd_pkg::*;

  cfg_t cfg;
  logic take;
  logic emit;
  res_t res_word;
  res_t res;

  // Configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_version <= VERSION_RESET;
      cfg.max_payload_len  <= MAX_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_VERSION: cfg.expected_version <= cfg_data[1:0];
        CFG_MAX_LEN: cfg.max_payload_len  <= cfg_data;
        default:     ;
      endcase
    end
  end

  // Take a byte unless a stalled word occupies the output register
  assign rx_stall = res_valid && res_stall;
  assign take     = rx_valid && !rx_stall;

  smuxfd_core u_core (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .rx_byte (rx_byte),
    .cfg     (cfg),
    .emit    (emit),
    .res     (res_word)
  );

  // Output register: load when empty or drained
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (!res_valid || !res_stall) begin
      res_valid <= take && emit;
    end
  end

  always_ff @(posedge clk) begin
    if ((!res_valid || !res_stall) && take && emit) begin
      res <= res_word;
    end
  end

  assign event_res     = res.event_res;
  assign command       = res.command;
  assign strm_id       = res.strm_id;
  assign data_byte     = res.data_byte;
  assign last_byte     = res.last_byte;
  assign peer_consumed = res.peer_consumed;
  assign peer_window   = res.peer_window;

  // A taken byte that produces a word shows it next cycle
  a_emit_to_valid: assert property (@(posedge clk) disable iff (rst)
    take && emit |=> res_valid)
    else $error("produced word not registered");

  // A stalled word is never overwritten by a new byte
  a_no_take_stalled: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |-> !take)
    else $error("byte taken over a stalled word");

  // Valid word without a producing byte must be a held one
  a_valid_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(take && emit))
    else $error("output valid without a producing byte");

endmodule
